// ===== design/lfu_min_heap_tracker_unit_defines.svh =====
// Assertion macros shared by the checker files of the LFU heap tracker.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef LFU_MIN_HEAP_TRACKER_UNIT_DEFINES_SVH
`define LFU_MIN_HEAP_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu check failed");

// next-cycle implication
`define LFU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu check failed");

`endif

// ===== design/lfu_pkg.sv =====
// Package for the LFU heap tracker: sizes, entry type, codes and the
// controller/datapath command and status structs. No dependencies.
package lfu_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;
  localparam int ID_W     = 8;
  localparam int COUNT_W  = 16;
  localparam int STAMP_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    KIND_TOUCH  = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RD_SRCH   = 3'd0,
    RD_PARENT = 3'd1,
    RD_LEFT   = 3'd2,
    RD_RIGHT  = 3'd3,
    RD_LAST   = 3'd4,
    RD_TOP    = 3'd5
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_UPPER = 2'd1,
    WR_CUR   = 2'd2,
    WR_CAND  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    srch_inc;
    logic    found_set;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cur_touch;
    logic    cur_new;
    logic    cur_load;
    logic    pos_slot;
    logic    pos_parent;
    logic    pos_cand;
    logic    total_dec;
    logic    moved_set;
    logic    best_load;
    logic    set_full;
    logic    set_nf;
    logic    cnt_cur;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  id_zero;
    logic  total_zero;
    logic  full;
    logic  found;
    logic  match;
    logic  srch_last;
    logic  slot_last;
    logic  pos_zero;
    logic  up_better;
    logic  left_ok;
    logic  cand_better;
    logic  moved;
    logic  out_busy;
  } sts_t;

  // a sits above b: lower count, then earlier stamp
  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.count != b.count) return a.count < b.count;
    return a.stamp < b.stamp;
  endfunction

endpackage

// ===== design/lfu_ifs.sv =====
// Valid/ready channel interfaces for the LFU heap tracker.
// Depends on lfu_pkg.
interface lfu_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [lfu_pkg::ID_W-1:0]  id;
  modport source (output valid, kind, id, input ready);
  modport sink   (input valid, kind, id, output ready);
endinterface

interface lfu_out_if;
  logic                         valid;
  logic                         ready;
  logic [lfu_pkg::ID_W-1:0]     top_id;
  logic                         top_valid;
  logic [lfu_pkg::COUNT_W-1:0]  id_count;
  logic [1:0]                   status;
  modport source (output valid, top_id, top_valid, id_count, status, input ready);
  modport sink   (input valid, top_id, top_valid, id_count, status, output ready);
endinterface

// ===== design/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lfu_ctrl.sv =====
// Controller FSM of the LFU heap tracker: search, insert, sift and report.
// Depends on lfu_pkg; drives lfu_dp through cmd_t, reads sts_t.
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfu_pkg::sts_t sts,
  output lfu_pkg::cmd_t cmd
);
  import lfu_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SRCH_RD  = 12'b000000000010,
    S_SRCH_CHK = 12'b000000000100,
    S_DISP     = 12'b000000001000,
    S_RM_LD    = 12'b000000010000,
    S_UP_RD    = 12'b000000100000,
    S_UP_CHK   = 12'b000001000000,
    S_DN_L     = 12'b000010000000,
    S_DN_R     = 12'b000100000000,
    S_DN_C     = 12'b001000000000,
    S_TOP      = 12'b010000000000,
    S_TOP_CHK  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   up_stop_down;

  assign in_ready     = (state == S_IDLE);
  assign up_stop_down = (sts.kind == KIND_REMOVE) && !sts.moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SRCH;
    cmd.wr_sel = WR_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (sts.id_zero) begin
            cmd.set_nf = 1'b1;
            state_next = S_TOP;
          end else if (sts.total_zero) begin
            state_next = S_DISP;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        cmd.rd_sel = RD_SRCH;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (sts.match) begin
          cmd.found_set = 1'b1;
          state_next    = S_DISP;
        end else if (sts.srch_last) begin
          state_next = S_DISP;
        end else begin
          cmd.srch_inc = 1'b1;
          state_next   = S_SRCH_RD;
        end
      end
      S_DISP: begin
        state_next = S_TOP;
        if (sts.kind == KIND_TOUCH) begin
          if (sts.found) begin
            cmd.cur_touch = 1'b1;
            cmd.pos_slot  = 1'b1;
            state_next    = S_DN_L;
          end else if (sts.full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.cur_new = 1'b1;
            state_next  = S_UP_RD;
          end
        end else if (!sts.found) begin
          cmd.set_nf = 1'b1;
        end else if (sts.kind == KIND_REMOVE) begin
          cmd.total_dec = 1'b1;
          cmd.rd_sel    = RD_LAST;
          if (!sts.slot_last) begin
            cmd.pos_slot = 1'b1;
            state_next   = S_RM_LD;
          end
        end else begin
          cmd.cnt_cur = 1'b1;
        end
      end
      S_RM_LD: begin
        cmd.cur_load = 1'b1;
        state_next   = S_UP_RD;
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          if (up_stop_down) begin
            state_next = S_DN_L;
          end else begin
            cmd.wr_sel = WR_CUR;
            state_next = S_TOP;
          end
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts.up_better) begin
          cmd.wr_sel     = WR_UPPER;
          cmd.pos_parent = 1'b1;
          cmd.moved_set  = 1'b1;
          state_next     = S_UP_RD;
        end else if (up_stop_down) begin
          state_next = S_DN_L;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_next = S_TOP;
        end
      end
      S_DN_L: begin
        if (sts.left_ok) begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_R;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_next = S_TOP;
        end
      end
      S_DN_R: begin
        cmd.best_load = 1'b1;
        cmd.rd_sel    = RD_RIGHT;
        state_next    = S_DN_C;
      end
      S_DN_C: begin
        if (sts.cand_better) begin
          cmd.wr_sel   = WR_CAND;
          cmd.pos_cand = 1'b1;
          state_next   = S_DN_L;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        cmd.rd_sel = RD_TOP;
        state_next = S_TOP_CHK;
      end
      S_TOP_CHK: begin
        cmd.rd_sel = RD_TOP;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ===== design/lfu_dp.sv =====
// Datapath of the LFU heap tracker: heap RAM, working entry, indices,
// counters and the output register. Depends on lfu_pkg and lfu_ram.
module lfu_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   in_kind,
  input  logic [lfu_pkg::ID_W-1:0]     in_id,
  input  lfu_pkg::cmd_t                cmd,
  output lfu_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lfu_pkg::ID_W-1:0]     top_id,
  output logic                         top_valid,
  output logic [lfu_pkg::COUNT_W-1:0]  id_count,
  output logic [1:0]                   status
);
  import lfu_pkg::*;

  kind_t               kind;
  logic [ID_W-1:0]     id;
  logic [CNT_W-1:0]    srch;
  logic [IDX_W-1:0]    slot;
  logic                found;
  logic                moved;
  entry_t              cur;
  entry_t              best;
  logic [IDX_W-1:0]    best_idx;
  logic                right_ok_r;
  logic [IDX_W-1:0]    pos;
  logic [CNT_W-1:0]    total;
  logic [STAMP_W-1:0]  arrival;
  status_t             res_status;
  logic [COUNT_W-1:0]  res_count;

  entry_t              rd_data;
  entry_t              wdata;
  entry_t              cand;
  logic                we;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    parent;
  logic [IDX_W-1:0]    cand_idx;
  logic [CH_W-1:0]     left;
  logic [CH_W-1:0]     right;
  logic                right_ok;
  logic [COUNT_W-1:0]  count_sat;
  logic [CNT_W-1:0]    total_m1;

  lfu_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign parent    = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign left      = CH_W'({pos, 1'b1});
  assign right     = left + CH_W'(1);
  assign right_ok  = right < CH_W'(total);
  assign total_m1  = total - CNT_W'(1);
  assign count_sat = (cur.count == COUNT_MAX) ? COUNT_MAX : cur.count + COUNT_W'(1);
  assign cand      = (right_ok_r && goes_before(rd_data, best)) ? rd_data : best;
  assign cand_idx  = (right_ok_r && goes_before(rd_data, best)) ?
                     best_idx + IDX_W'(1) : best_idx;

  always_comb begin
    case (cmd.rd_sel)
      RD_SRCH:   raddr = srch[IDX_W-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = left[IDX_W-1:0];
      RD_RIGHT:  raddr = right[IDX_W-1:0];
      RD_LAST:   raddr = total_m1[IDX_W-1:0];
      RD_TOP:    raddr = '0;
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    we = 1'b1;
    case (cmd.wr_sel)
      WR_UPPER: wdata = rd_data;
      WR_CUR:   wdata = cur;
      WR_CAND:  wdata = cand;
      default: begin
        wdata = cur;
        we    = 1'b0;
      end
    endcase
  end

  always_comb begin
    sts.kind        = kind;
    sts.id_zero     = (in_id == '0);
    sts.total_zero  = (total == '0);
    sts.full        = (total == CNT_W'(CAPACITY));
    sts.found       = found;
    sts.match       = (rd_data.id == id);
    sts.srch_last   = (srch + CNT_W'(1) == total);
    sts.slot_last   = (CNT_W'(slot) == total_m1);
    sts.pos_zero    = (pos == '0);
    sts.up_better   = goes_before(cur, rd_data);
    sts.left_ok     = left < CH_W'(total);
    sts.cand_better = goes_before(cand, cur);
    sts.moved       = moved;
    sts.out_busy    = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      arrival   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cur_new) begin
        total   <= total + CNT_W'(1);
        arrival <= arrival + STAMP_W'(1);
      end else if (cmd.total_dec) begin
        total <= total_m1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind       <= kind_t'(in_kind);
      id         <= in_id;
      srch       <= '0;
      found      <= 1'b0;
      moved      <= 1'b0;
      res_count  <= '0;
    end
    if (cmd.srch_inc) begin
      srch <= srch + CNT_W'(1);
    end
    if (cmd.found_set) begin
      found <= 1'b1;
      slot  <= srch[IDX_W-1:0];
      cur   <= rd_data;
    end
    if (cmd.cur_touch) begin
      cur.count <= count_sat;
      res_count <= count_sat;
    end
    if (cmd.cur_new) begin
      cur       <= '{id: id, count: COUNT_W'(1), stamp: arrival};
      pos       <= total[IDX_W-1:0];
      res_count <= COUNT_W'(1);
    end
    if (cmd.cur_load) begin
      cur <= rd_data;
    end
    if (cmd.cnt_cur) begin
      res_count <= cur.count;
    end
    if (cmd.set_nf) begin
      res_status <= ST_NOT_FOUND;
    end else if (cmd.set_full) begin
      res_status <= ST_FULL;
    end else if (cmd.latch_in) begin
      res_status <= ST_OK;
    end
    if (cmd.pos_slot) begin
      pos <= slot;
    end else if (cmd.pos_parent) begin
      pos <= parent;
    end else if (cmd.pos_cand) begin
      pos <= cand_idx;
    end
    if (cmd.moved_set) begin
      moved <= 1'b1;
    end
    if (cmd.best_load) begin
      best       <= rd_data;
      best_idx   <= left[IDX_W-1:0];
      right_ok_r <= right_ok;
    end
    if (cmd.out_load) begin
      top_valid <= (total != '0);
      top_id    <= (total != '0) ? rd_data.id : '0;
      id_count  <= res_count;
      status    <= res_status;
    end
  end
endmodule

// ===== design/lfu_min_heap_tracker_unit.sv =====
// Top level of the LFU heap tracker: controller plus datapath.
// Depends on lfu_pkg, lfu_ifs, lfu_ram, lfu_ctrl and lfu_dp.
//
// Usage:
//   in_ch  carries one operation (kind, id): touch, remove or look up.
//   out_ch returns one result per operation: heap top id and its valid
//   flag, the id's count and a status code (ok, full, not found).
//   One operation is in work at a time; in_ch.ready is high only between
//   operations. The heap sits in a single-port-read RAM, so every step of
//   the id search and of the sift costs RAM reads with registered data.
//   An id of zero is answered as not found without a search; else the
//   stored slots are searched in turn. An update then moves the entry up
//   or down one level per step and ends with a final write; a remove first
//   refills the emptied slot from the last entry. The next transfer is
//   taken the cycle after the result is loaded.
//   A finished result waits in the output register; a new operation may
//   be taken and worked on meanwhile, and holds in its last step while
//   out_ch is stalled.
//   Reset (rst, synchronous) empties the heap and zeroes the stamp counter;
//   no clearing pass is needed and the block is ready the cycle after.
module lfu_min_heap_tracker_unit (
  input logic clk,
  input logic rst,
  lfu_in_if.sink    in_ch,
  lfu_out_if.source out_ch
);
  import lfu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_kind   (in_ch.kind),
    .in_id     (in_ch.id),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .top_id    (out_ch.top_id),
    .top_valid (out_ch.top_valid),
    .id_count  (out_ch.id_count),
    .status    (out_ch.status)
  );
endmodule

// ===== design/lfu_chk.sv =====
// Port-level checker for the LFU heap tracker, bound to the top level.
// Depends on lfu_pkg and lfu_min_heap_tracker_unit_defines.svh.
`include "lfu_min_heap_tracker_unit_defines.svh"

module lfu_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lfu_pkg::ID_W-1:0]     top_id,
  input logic                         top_valid,
  input logic [lfu_pkg::COUNT_W-1:0]  id_count,
  input logic [1:0]                   status
);
  import lfu_pkg::*;

  `LFU_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `LFU_ASSERT_NOW(a_top_consistent, out_valid, (top_valid == (top_id != '0)))
  `LFU_ASSERT_NOW(a_fail_zero_count, out_valid && (status != ST_OK), id_count == '0)
  `LFU_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(top_id) && $stable(id_count) && $stable(status))
endmodule

bind lfu_min_heap_tracker_unit lfu_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .top_id    (out_ch.top_id),
  .top_valid (out_ch.top_valid),
  .id_count  (out_ch.id_count),
  .status    (out_ch.status)
);
